// ===== sv/block_size_negotiate_encode_defines.svh =====
// assertion macros for the block size negotiation encoder
`ifndef BLOCK_SIZE_NEGOTIATE_ENCODE_DEFINES_SVH
`define BLOCK_SIZE_NEGOTIATE_ENCODE_DEFINES_SVH

`ifndef SYNTHESIS

// condition must hold in the same cycle as the trigger
`define BSNE_ASSERT_IMPL(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error("bsne: implication check failed");

// condition must hold in the cycle after the trigger
`define BSNE_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("bsne: next-cycle check failed");

`else

`define BSNE_ASSERT_IMPL(label, clk, rst_n, trig, cond)
`define BSNE_ASSERT_NEXT(label, clk, rst_n, trig, cond)

`endif

`endif

// ===== sv/bsne_pkg.sv =====
// shared types, constants and helpers of the block size negotiation encoder
`timescale 1ns / 1ps
`default_nettype none

package bsne_pkg;

	// field widths
	localparam int unsigned NUM_W     = 20;
	localparam int unsigned SZX_W     = 3;
	localparam int unsigned PAYLOAD_W = 32;
	localparam int unsigned MSG_W     = 16;
	localparam int unsigned ONUM_W    = 26;
	localparam int unsigned VAL_W     = 30;
	localparam int unsigned OLEN_W    = 3;
	localparam int unsigned STATUS_W  = 2;

	// internal widths
	localparam int unsigned START_W = 30;  // block number shifted by at most ten
	localparam int unsigned WANT_W  = 11;  // block size up to 1024
	localparam int unsigned SHIFT_W = 4;   // exponent plus bias
	localparam int unsigned HBP_W   = 5;   // bit position of a 16 bit value, 0..16

	// constants
	localparam logic [MSG_W-1:0] MSG_MAX_RESET       = 16'd1152;
	localparam int unsigned      RESERVED_BYTES      = 4;
	localparam int unsigned      MIN_AVAIL           = 16;
	localparam int unsigned      SZX_BIAS            = 4;
	localparam int unsigned      HBP_BIAS            = 5;
	localparam logic [SZX_W-1:0] SZX_MAX             = 3'd6;
	localparam int unsigned      LENGTH_BITS_DEFAULT = 32;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_ILLEGAL = 2'd1,
		STATUS_NOSPACE = 2'd2
	} status_t;

	// size decision handed to the encode stage
	typedef struct packed {
		status_t            status;
		logic               more;
		logic [SZX_W-1:0]   szx;
	} fit_t;

	// one finished result
	typedef struct packed {
		status_t             status;
		logic [ONUM_W-1:0]   num;
		logic                more;
		logic [SZX_W-1:0]    szx;
		logic [VAL_W-1:0]    value;
		logic [OLEN_W-1:0]   olen;
	} result_t;

	// one plus the index of the highest set bit, zero for zero
	function automatic logic [HBP_W-1:0] highest_bit_pos(input logic [MSG_W-1:0] v);
		logic [HBP_W-1:0] pos;
		pos = '0;
		for (int i = 0; i < MSG_W; i++) begin
			if (v[i]) begin
				pos = HBP_W'(i + 1);
			end
		end
		return pos;
	endfunction

endpackage

`default_nettype wire

// ===== sv/bsne_encode.sv =====
// final stage: block number rescale, option value packing and byte length
`timescale 1ns / 1ps
`default_nettype none

module bsne_encode (
	input  logic [bsne_pkg::NUM_W-1:0] num,
	input  logic [bsne_pkg::SZX_W-1:0] shamt,
	input  bsne_pkg::fit_t             fit,
	output bsne_pkg::result_t          res
);
	import bsne_pkg::*;

	logic [ONUM_W-1:0] num_w;
	logic [VAL_W-1:0]  value_w;

	always_comb begin
		num_w   = ONUM_W'(num) << shamt;
		value_w = {num_w, fit.more, fit.szx};

		res        = '0;
		res.status = fit.status;
		if (fit.status == STATUS_OK) begin
			res.num   = num_w;
			res.more  = fit.more;
			res.szx   = fit.szx;
			res.value = value_w;
			priority if (value_w[29:24] != '0) begin
				res.olen = 3'd4;
			end else if (value_w[23:16] != '0) begin
				res.olen = 3'd3;
			end else if (value_w[15:8] != '0) begin
				res.olen = 3'd2;
			end else if (value_w[7:0] != '0) begin
				res.olen = 3'd1;
			end else begin
				res.olen = 3'd0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/block_size_negotiate_encode.sv =====
// top level: four stage pipeline for block size negotiation and option encoding
`timescale 1ns / 1ps
`default_nettype none

// channel   handshake               payload
// -------   ---------------------   ------------------------------------------------
// cfg       cfg_valid / cfg_ready   message_max_size
// in        in_valid / in_ready     block_number, size_exponent, payload_length,
//                                   used_bytes
// out       out_valid / out_ready   status, out_block_number, more_flag,
//                                   out_size_exponent, option_value, option_length
//
// one transfer per cycle sustained while out_ready stays high; an input reaches the output
// through the four register stages (shift and space, length compare, size decision, encode)
// in order; cfg_ready is always high
// reset clears all stage valid bits and loads message_max_size with 1152
// low out_ready holds the output stage; bubbles upstream still close up, and
// in_ready falls only once every stage holds an item

module block_size_negotiate_encode #(
	parameter int unsigned LENGTH_BITS = bsne_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bsne_pkg::MSG_W-1:0]    message_max_size,

	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bsne_pkg::NUM_W-1:0]    block_number,
	input  logic [bsne_pkg::SZX_W-1:0]    size_exponent,
	input  logic [bsne_pkg::PAYLOAD_W-1:0] payload_length,
	input  logic [bsne_pkg::MSG_W-1:0]    used_bytes,

	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bsne_pkg::STATUS_W-1:0] status,
	output logic [bsne_pkg::ONUM_W-1:0]   out_block_number,
	output logic                          more_flag,
	output logic [bsne_pkg::SZX_W-1:0]    out_size_exponent,
	output logic [bsne_pkg::VAL_W-1:0]    option_value,
	output logic [bsne_pkg::OLEN_W-1:0]   option_length
);
	import bsne_pkg::*;

`include "block_size_negotiate_encode_defines.svh"

	// only the low LENGTH_BITS of the payload length count
	localparam int unsigned LEN_W = (LENGTH_BITS < PAYLOAD_W) ? LENGTH_BITS : PAYLOAD_W;

	// configuration register
	logic [MSG_W-1:0] msg_max_q;

	// stage handshake
	logic ready_s1, ready_s2, ready_s3, ready_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	// stage 1: clamp, block start, wanted size, free space
	logic [SZX_W-1:0]   szx_c;
	logic [SHIFT_W-1:0] shift_c;
	logic [START_W-1:0] start_c;
	logic [WANT_W-1:0]  want_c;
	logic [MSG_W:0]     need_c;
	logic [MSG_W:0]     max_c;
	logic [MSG_W-1:0]   avail_c;

	logic [NUM_W-1:0]   num_s1;
	logic [SZX_W-1:0]   szx_s1;
	logic [START_W-1:0] start_s1;
	logic [LEN_W-1:0]   length_s1;
	logic [WANT_W-1:0]  want_s1;
	logic [MSG_W-1:0]   avail_s1;

	// stage 2: illegal check, rest of the payload, fit of the wanted size
	logic [PAYLOAD_W-1:0] len_ext_c;
	logic [PAYLOAD_W-1:0] start_ext_c;
	logic                 illegal_c;
	logic [PAYLOAD_W-1:0] rest_c;
	logic                 fits_c;

	logic [NUM_W-1:0]     num_s2;
	logic [SZX_W-1:0]     szx_s2;
	logic [WANT_W-1:0]    want_s2;
	logic [MSG_W-1:0]     avail_s2;
	logic [PAYLOAD_W-1:0] rest_s2;
	logic                 illegal_s2;
	logic                 fits_s2;

	// stage 3: size decision
	logic [HBP_W-1:0] hbp_c;
	logic [HBP_W-1:0] nszx_c;
	fit_t             fit_c;
	logic [SZX_W-1:0] shamt_c;

	logic [NUM_W-1:0] num_s3;
	fit_t             fit_s3;
	logic [SZX_W-1:0] shamt_s3;

	// stage 4: encoded result, doubles as the output register
	result_t res_c;
	result_t res_s4;

	// configuration port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_max_q <= MSG_MAX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			msg_max_q <= message_max_size;
		end
	end

	// a stage takes a new item when empty or when its item moves on
	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// stage 1 logic
	always_comb begin
		// reserved exponent seven acts as six
		szx_c   = (size_exponent > SZX_MAX) ? SZX_MAX : size_exponent;
		shift_c = SHIFT_W'(szx_c) + SHIFT_W'(SZX_BIAS);
		start_c = START_W'(block_number) << shift_c;
		want_c  = WANT_W'(1) << shift_c;
		// free space saturates at zero
		need_c  = (MSG_W + 1)'(used_bytes) + (MSG_W + 1)'(RESERVED_BYTES);
		max_c   = (MSG_W + 1)'(msg_max_q);
		avail_c = (max_c >= need_c) ? MSG_W'(max_c - need_c) : '0;
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			num_s1    <= block_number;
			szx_s1    <= szx_c;
			start_s1  <= start_c;
			length_s1 <= payload_length[LEN_W-1:0];
			want_s1   <= want_c;
			avail_s1  <= avail_c;
		end
	end

	// stage 2 logic
	always_comb begin
		len_ext_c   = PAYLOAD_W'(length_s1);
		start_ext_c = PAYLOAD_W'(start_s1);
		// block must start inside the payload
		illegal_c   = (len_ext_c <= start_ext_c);
		rest_c      = len_ext_c - start_ext_c;
		fits_c      = (MSG_W'(want_s1) <= avail_s1);
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			num_s2     <= num_s1;
			szx_s2     <= szx_s1;
			want_s2    <= want_s1;
			avail_s2   <= avail_s1;
			rest_s2    <= rest_c;
			illegal_s2 <= illegal_c;
			fits_s2    <= fits_c;
		end
	end

	// stage 3 logic
	always_comb begin
		hbp_c   = highest_bit_pos(avail_s2);
		nszx_c  = hbp_c - HBP_W'(HBP_BIAS);
		fit_c   = '{status: STATUS_OK, more: 1'b0, szx: szx_s2};
		shamt_c = '0;
		priority if (illegal_s2) begin
			fit_c.status = STATUS_ILLEGAL;
			fit_c.szx    = '0;
		end else if (fits_s2) begin
			// requested size fits the message
			fit_c.more = (PAYLOAD_W'(want_s2) < rest_s2);
		end else if (PAYLOAD_W'(avail_s2) >= rest_s2) begin
			// last piece of the payload fits as is
			fit_c.more = 1'b0;
		end else if (avail_s2 < MSG_W'(MIN_AVAIL)) begin
			fit_c.status = STATUS_NOSPACE;
			fit_c.szx    = '0;
		end else begin
			// shrink to the largest power of two that fits, rescale the number
			fit_c.szx  = nszx_c[SZX_W-1:0];
			fit_c.more = 1'b1;
			shamt_c    = szx_s2 - nszx_c[SZX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			num_s3   <= num_s2;
			fit_s3   <= fit_c;
			shamt_s3 <= shamt_c;
		end
	end

	// stage 4: rescale and pack
	bsne_encode u_encode (
		.num   (num_s3),
		.shamt (shamt_s3),
		.fit   (fit_s3),
		.res   (res_c)
	);

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			res_s4 <= res_c;
		end
	end

	// output port
	assign out_valid         = valid_s4;
	assign status            = res_s4.status;
	assign out_block_number  = res_s4.num;
	assign more_flag         = res_s4.more;
	assign out_size_exponent = res_s4.szx;
	assign option_value      = res_s4.value;
	assign option_length     = res_s4.olen;

	// error results carry no option
	`BSNE_ASSERT_IMPL(a_err_zero, clk, arst_n, out_valid && (status != STATUS_OK),
		(option_value == '0) && (option_length == '0) && !more_flag)
	// packed value agrees with the separate fields
	`BSNE_ASSERT_IMPL(a_pack, clk, arst_n, out_valid && (status == STATUS_OK),
		(option_value[2:0] == out_size_exponent) && (option_value[3] == more_flag)
		&& (out_size_exponent <= SZX_MAX))
	// an empty output stage means the whole pipe can advance
	`BSNE_ASSERT_IMPL(a_ready, clk, arst_n, !out_valid, in_ready)
	// an item in stage 3 with stage 4 empty reaches the output next cycle
	`BSNE_ASSERT_NEXT(a_advance, clk, arst_n, valid_s3 && !valid_s4, out_valid)

endmodule

`default_nettype wire
